@@ sv/pairwise_euclidean_distance_assert.svh @@
// Assertion macros shared by the pairwise distance checker.
// No dependencies; expects clk and rst in the scope of each use.
`ifndef PAIRWISE_EUCLIDEAN_DISTANCE_ASSERT_SVH
`define PAIRWISE_EUCLIDEAN_DISTANCE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define PWED_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define PWED_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ sv/pwed_pkg.sv @@
// Shared types and fixed widths for the pairwise distance block.
// No dependencies.
`timescale 1ns / 1ps

package pwed_pkg;

  localparam int COORD_W = 16;
  localparam int CFG_W   = 5;
  localparam int IDX_W   = 6;
  localparam int NORM_W  = 35;
  localparam int PROD_W  = 32;
  localparam int DOT_W   = 40;
  localparam int SUM_W   = 42;
  localparam int SQ_W    = 38;
  localparam int DIST_W  = 19;
  localparam int REM_W   = 22;
  localparam int STEP_W  = 5;

  localparam logic [CFG_W-1:0] N_DIMS_RESET = CFG_W'(2);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_DRAIN,
    ST_DIST,
    ST_SQRT,
    ST_OUT
  } pwed_state_t;

endpackage

@@ sv/pairwise_euclidean_distance.sv @@
// Pairwise squared and plain Euclidean distance over a streamed point set.
// Depends on pwed_pkg and pwed_isqrt.
//
//   channel  handshake            payload
//   in       in_valid/in_stall    coord_value, new_set
//   out      out_valid/out_stall  row_index, col_index, squared_distance,
//                                 distance, last, store_full
//   cfg      cfg_valid/cfg_ready  cfg_data (n_dims)
//
// A coordinate that does not finish a point leaves the block idle.
// A finished point j runs one pair at a time against each earlier point, in
// turn through the single MAC over the coordinate memory and the 19-step
// square root unit. The input stalls until the last beat is loaded.
// Reset is synchronous; memories are not cleared, only counts and control.
`timescale 1ns / 1ps

module pairwise_euclidean_distance #(
  parameter int MAX_POINTS = 64,
  parameter int MAX_DIMS   = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [pwed_pkg::COORD_W-1:0] coord_value,
  input  logic                                new_set,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [pwed_pkg::IDX_W-1:0]          row_index,
  output logic [pwed_pkg::IDX_W-1:0]          col_index,
  output logic [pwed_pkg::SQ_W-1:0]           squared_distance,
  output logic [pwed_pkg::DIST_W-1:0]         distance,
  output logic                                last,
  output logic                                store_full,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [pwed_pkg::CFG_W-1:0]          cfg_data
);

  localparam int PA  = $clog2(MAX_POINTS);
  localparam int PCW = $clog2(MAX_POINTS + 1);
  localparam int DW  = $clog2(MAX_DIMS + 1);
  localparam int DA  = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
  localparam int AW  = PA + DA;

  logic [pwed_pkg::COORD_W-1:0] cmem [0:(1 << AW)-1];
  logic [pwed_pkg::NORM_W-1:0]  nmem [0:MAX_POINTS-1];

  pwed_pkg::pwed_state_t state, state_next;

  logic [pwed_pkg::CFG_W-1:0]  n_dims;
  logic [PCW-1:0]              point_count;
  logic [DW-1:0]               dim_count;
  logic [pwed_pkg::NORM_W-1:0] norm_acc;
  logic [pwed_pkg::NORM_W-1:0] norm_j;
  logic [pwed_pkg::NORM_W-1:0] norm_i;
  logic [PA-1:0]               pt_i;
  logic [PA-1:0]               pt_j;
  logic [DW-1:0]               d;
  logic signed [pwed_pkg::COORD_W-1:0] rd_a, rd_b;
  logic signed [pwed_pkg::PROD_W-1:0]  prod;
  logic signed [pwed_pkg::DOT_W-1:0]   dot;
  logic                        v1, v2;

  logic                        in_acc, cfg_acc, out_free, out_load;
  logic [6:0]                  nd_w;
  logic [DW-1:0]               dims_eff;
  logic [DW-1:0]               dc_base, dc_inc;
  logic [PCW-1:0]              pc_base;
  logic [pwed_pkg::NORM_W-1:0] acc_base, norm_next;
  logic [pwed_pkg::PROD_W-1:0] x_sq;
  logic                        full, complete, pair_last;
  logic signed [pwed_pkg::SUM_W-1:0] sum;
  logic [pwed_pkg::SQ_W-1:0]   sq_val, sq_reg;
  logic                        sqrt_done;
  logic [pwed_pkg::DIST_W-1:0] sqrt_root;

  assign out_free  = !out_valid || !out_stall;
  assign cfg_ready = (state == pwed_pkg::ST_IDLE);
  assign in_stall  = (state != pwed_pkg::ST_IDLE) || !out_free || cfg_valid;
  assign in_acc    = in_valid && !in_stall;
  assign cfg_acc   = cfg_valid && cfg_ready;
  assign out_load  = ((state == pwed_pkg::ST_IDLE) && in_acc && complete && full)
                  || ((state == pwed_pkg::ST_OUT) && out_free);

  // clamp the register to 1..MAX_DIMS
  always_comb begin
    nd_w = {2'b00, n_dims};
    if (nd_w == 7'd0) begin
      dims_eff = DW'(1);
    end else if (nd_w > 7'(MAX_DIMS)) begin
      dims_eff = DW'(MAX_DIMS);
    end else begin
      dims_eff = DW'(nd_w);
    end
  end

  always_comb begin
    pc_base   = new_set ? '0 : point_count;
    dc_base   = (new_set || dim_count >= dims_eff) ? '0 : dim_count;
    dc_inc    = dc_base + 1'b1;
    acc_base  = new_set ? '0 : norm_acc;
    x_sq      = pwed_pkg::PROD_W'(coord_value) * pwed_pkg::PROD_W'(coord_value);
    norm_next = acc_base + pwed_pkg::NORM_W'(x_sq);
    full      = (pc_base == PCW'(MAX_POINTS));
    complete  = (dc_inc == dims_eff);
    pair_last = (PA'(pt_i + 1'b1) == pt_j);
  end

  always_comb begin
    sum = $signed({{(pwed_pkg::SUM_W-pwed_pkg::NORM_W){1'b0}}, norm_i})
        + $signed({{(pwed_pkg::SUM_W-pwed_pkg::NORM_W){1'b0}}, norm_j})
        - ($signed(pwed_pkg::SUM_W'(dot)) <<< 1);
    sq_val = sum[pwed_pkg::SUM_W-1] ? '0 : sum[pwed_pkg::SQ_W-1:0];
  end

  always_comb begin
    state_next = state;
    unique case (state)
      pwed_pkg::ST_IDLE: begin
        if (in_acc && complete && !full && pc_base != '0) begin
          state_next = pwed_pkg::ST_ISSUE;
        end
      end
      pwed_pkg::ST_ISSUE: begin
        if (d == dims_eff - 1'b1) begin
          state_next = pwed_pkg::ST_DRAIN;
        end
      end
      pwed_pkg::ST_DRAIN: begin
        if (!v1 && !v2) begin
          state_next = pwed_pkg::ST_DIST;
        end
      end
      pwed_pkg::ST_DIST: state_next = pwed_pkg::ST_SQRT;
      pwed_pkg::ST_SQRT: begin
        if (sqrt_done) begin
          state_next = pwed_pkg::ST_OUT;
        end
      end
      pwed_pkg::ST_OUT: begin
        if (out_free) begin
          state_next = pair_last ? pwed_pkg::ST_IDLE : pwed_pkg::ST_ISSUE;
        end
      end
      default: state_next = pwed_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pwed_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // memories: one write port each, two coordinate reads, one norm read
  always_ff @(posedge clk) begin
    if (in_acc && !full) begin
      cmem[{pc_base[PA-1:0], dc_base[DA-1:0]}] <= coord_value;
    end
    if (in_acc && complete && !full) begin
      nmem[pc_base[PA-1:0]] <= norm_next;
    end
    rd_a   <= cmem[{pt_i, d[DA-1:0]}];
    rd_b   <= cmem[{pt_j, d[DA-1:0]}];
    norm_i <= nmem[pt_i];
  end

  // MAC pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= (state == pwed_pkg::ST_ISSUE);
      v2 <= v1;
    end
    prod <= rd_a * rd_b;
    if ((state == pwed_pkg::ST_IDLE) || (state == pwed_pkg::ST_OUT)) begin
      dot <= '0;
    end else if (v2) begin
      dot <= dot + pwed_pkg::DOT_W'(prod);
    end
    if (state == pwed_pkg::ST_DIST) begin
      sq_reg <= sq_val;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      n_dims      <= pwed_pkg::N_DIMS_RESET;
      point_count <= '0;
      dim_count   <= '0;
      norm_acc    <= '0;
      out_valid   <= 1'b0;
      d           <= '0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (cfg_acc) begin
        n_dims      <= cfg_data;
        point_count <= '0;
        dim_count   <= '0;
        norm_acc    <= '0;
      end
      unique case (state)
        pwed_pkg::ST_IDLE: begin
          d <= '0;
          if (in_acc) begin
            if (complete) begin
              dim_count <= '0;
              norm_acc  <= '0;
              if (full) begin
                point_count      <= pc_base;
                row_index        <= '0;
                col_index        <= '0;
                squared_distance <= '0;
                distance         <= '0;
                last             <= 1'b1;
                store_full       <= 1'b1;
              end else begin
                point_count <= pc_base + 1'b1;
                norm_j      <= norm_next;
                pt_j        <= pc_base[PA-1:0];
                pt_i        <= '0;
              end
            end else begin
              point_count <= pc_base;
              dim_count   <= dc_inc;
              norm_acc    <= norm_next;
            end
          end
        end
        pwed_pkg::ST_ISSUE: begin
          d <= d + 1'b1;
        end
        pwed_pkg::ST_OUT: begin
          d <= '0;
          if (out_free) begin
            row_index        <= pwed_pkg::IDX_W'(pt_i);
            col_index        <= pwed_pkg::IDX_W'(pt_j);
            squared_distance <= sq_reg;
            distance         <= sqrt_root;
            last             <= pair_last;
            store_full       <= 1'b0;
            pt_i             <= pt_i + 1'b1;
          end
        end
        default: begin
          d <= d;
        end
      endcase
    end
  end

  pwed_isqrt u_isqrt (
    .clk   (clk),
    .rst   (rst),
    .start (state == pwed_pkg::ST_DIST),
    .value (sq_val),
    .done  (sqrt_done),
    .root  (sqrt_root)
  );

endmodule

@@ sv/pwed_isqrt.sv @@
// Floor square root, two radicand bits per cycle, restoring form.
// Depends on pwed_pkg for widths.
`timescale 1ns / 1ps

module pwed_isqrt (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [pwed_pkg::SQ_W-1:0]    value,
  output logic                         done,
  output logic [pwed_pkg::DIST_W-1:0]  root
);

  logic [pwed_pkg::SQ_W-1:0]   rad;
  logic [pwed_pkg::REM_W-1:0]  rem;
  logic [pwed_pkg::STEP_W-1:0] step;
  logic                        busy;
  logic [pwed_pkg::REM_W-1:0]  rem_shift;
  logic [pwed_pkg::REM_W-1:0]  trial;
  logic                        fits;

  assign rem_shift = {rem[pwed_pkg::REM_W-3:0], rad[pwed_pkg::SQ_W-1 -: 2]};
  assign trial     = {1'b0, root, 2'b01};
  assign fits      = rem_shift >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        rad  <= value;
        rem  <= '0;
        root <= '0;
        step <= '0;
      end else if (busy) begin
        rad  <= {rad[pwed_pkg::SQ_W-3:0], 2'b00};
        rem  <= fits ? rem_shift - trial : rem_shift;
        root <= {root[pwed_pkg::DIST_W-2:0], fits};
        step <= step + 1'b1;
        if (step == pwed_pkg::STEP_W'(pwed_pkg::DIST_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

@@ sv/pwed_checker.sv @@
// Port-level checks for the pairwise distance block, bound to the top level.
// Depends on pwed_pkg and pairwise_euclidean_distance_assert.svh.
`timescale 1ns / 1ps
`include "pairwise_euclidean_distance_assert.svh"

module pwed_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic [pwed_pkg::IDX_W-1:0]  row_index,
  input logic [pwed_pkg::IDX_W-1:0]  col_index,
  input logic [pwed_pkg::SQ_W-1:0]   squared_distance,
  input logic [pwed_pkg::DIST_W-1:0] distance,
  input logic                        last,
  input logic                        store_full
);

  logic [2*pwed_pkg::DIST_W-1:0] dist_sq;
  assign dist_sq = distance * distance;

  `PWED_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(squared_distance) && $stable(row_index), "output beat changed while stalled")
  `PWED_ASSERT_IMP(a_full_beat, out_valid && store_full, last && squared_distance == '0 && row_index == '0 && col_index == '0, "store-full beat carries payload")
  `PWED_ASSERT_IMP(a_pair_order, out_valid && !store_full, row_index < col_index, "pair out of triangle order")
  `PWED_ASSERT_IMP(a_last_pair, out_valid && !store_full && last, pwed_pkg::IDX_W'(row_index + 1'b1) == col_index, "last flag on wrong pair")
  `PWED_ASSERT_IMP(a_root_floor, out_valid, pwed_pkg::SQ_W'(dist_sq) <= squared_distance, "root exceeds squared distance")

endmodule

bind pairwise_euclidean_distance pwed_checker u_pwed_checker (
  .clk              (clk),
  .rst              (rst),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .row_index        (row_index),
  .col_index        (col_index),
  .squared_distance (squared_distance),
  .distance         (distance),
  .last             (last),
  .store_full       (store_full)
);
